[rtl/core/rx_timing_window_checker_assert.svh]
// Assertion macros shared by the receive timing window checker modules.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef RX_TIMING_WINDOW_CHECKER_ASSERT_SVH
`define RX_TIMING_WINDOW_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RTWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtwc assertion failed");
`define RTWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtwc assertion failed");
`else
`define RTWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RTWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/rtwc_pkg.sv]
// Types, codes and constants of the receive timing window checker.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rtwc_pkg;

  // Frame numbers wrap at 2**FRAME_BITS frames
  localparam int FRAME_BITS = 8;
  localparam int LIN_W      = 20;
  localparam int ACC_W      = 17;
  localparam int RAW_W      = 21;
  localparam int DIST_W     = 21;
  localparam int OUT_DIST_W = 20;
  localparam int WIN_W      = 13;
  localparam int DELTA_W    = 32;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MSG    = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_ON_TIME = 2'd0;
  localparam logic [1:0] KIND_EARLY   = 2'd1;
  localparam logic [1:0] KIND_LATE    = 2'd2;
  localparam logic [1:0] KIND_REPORT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMEROLOGY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_PER_SLOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 3'd4;

  localparam logic [2:0] MU_MAX  = 3'd4;
  localparam logic [3:0] SPS_EXT = 4'd12;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] frame_number;
    logic [7:0] slot_number;
    logic [3:0] symbol_number;
  } in_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [OUT_DIST_W-1:0]  distance;
    logic [DELTA_W-1:0]            on_time_delta;
    logic [DELTA_W-1:0]            early_delta;
    logic [DELTA_W-1:0]            late_delta;
    logic signed [OUT_DIST_W-1:0]  earliest_distance;
    logic signed [OUT_DIST_W-1:0]  latest_distance;
  } out_t;

  // Effective configuration as seen by the datapath
  typedef struct packed {
    logic                     enable;
    logic [2:0]               mu;
    logic                     ext_cp;
    logic [LIN_W-1:0]         span;
    logic signed [WIN_W-1:0]  window_start;
    logic signed [WIN_W-1:0]  window_end;
  } cfg_t;

  // Queue entry: operation and linear symbol count
  typedef struct packed {
    logic [1:0]       op;
    logic [LIN_W-1:0] lin;
  } entry_t;

  function automatic logic [7:0] slots_per_frame(input logic [2:0] mu);
    return 8'd10 << mu;
  endfunction

  // Symbols in 2**FRAME_BITS frames: (10 * symbols per slot) << (mu + FRAME_BITS)
  function automatic logic [LIN_W-1:0] span_symbols(input logic [2:0] mu, input logic ext_cp);
    logic [LIN_W-1:0] base;
    base = ext_cp ? 20'd120 : 20'd140;
    return base << ({1'b0, mu} + 4'(FRAME_BITS));
  endfunction

endpackage
`default_nettype wire

[rtl/core/rtwc_fifo.sv]
// Short queue between the front (linearize) and back (classify) parts.
// Depends on rtwc_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
`include "rx_timing_window_checker_assert.svh"
module rtwc_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  rtwc_pkg::entry_t    push_data,
  output logic                full,
  input  wire logic           pop,
  output rtwc_pkg::entry_t    pop_data,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtwc_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `RTWC_ASSERT_IMP(a_fifo_no_overflow, clk, rst_n, push, !full)
  `RTWC_ASSERT_IMP(a_fifo_no_underflow, clk, rst_n, pop, !empty)

endmodule
`default_nettype wire

[rtl/core/rtwc_front.sv]
// Front part: accepts transactions, drops ignored ones and turns the
// time into a linear symbol count over two stages. Depends on rtwc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rx_timing_window_checker_assert.svh"
module rtwc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  rtwc_pkg::in_t     in_data,
  input  rtwc_pkg::cfg_t    cfg,
  output logic              push,
  output rtwc_pkg::entry_t  push_data,
  input  wire logic         full
);

  logic                           s1_v_r, s2_v_r;
  logic [rtwc_pkg::ACC_W-1:0]     s1_acc_r;
  logic [3:0]                     s1_sy_r;
  logic [1:0]                     s1_op_r, s2_op_r;
  logic [rtwc_pkg::LIN_W-1:0]     s2_lin_r;

  logic                           s1_adv, s2_adv, accept, keep;
  logic [rtwc_pkg::ACC_W-1:0]     s1_acc_nxt;
  logic [rtwc_pkg::RAW_W-1:0]     raw, fold;
  logic [rtwc_pkg::FRAME_BITS-1:0] fn;

  assign s2_adv   = !s2_v_r || !full;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;
  assign accept   = in_valid && in_ready;
  // drop everything while disabled, and the unused opcode always
  assign keep     = cfg.enable && (in_data.opcode != rtwc_pkg::OP_UNUSED);

  assign fn         = in_data.frame_number[rtwc_pkg::FRAME_BITS-1:0];
  assign s1_acc_nxt = rtwc_pkg::ACC_W'(fn) * rtwc_pkg::ACC_W'(rtwc_pkg::slots_per_frame(cfg.mu))
                    + rtwc_pkg::ACC_W'(in_data.slot_number);

  // The sum stays below twice the span, so one subtract folds it
  assign raw  = rtwc_pkg::RAW_W'(s1_acc_r) * (cfg.ext_cp ? 21'd12 : 21'd14)
              + rtwc_pkg::RAW_W'(s1_sy_r);
  assign fold = (raw >= rtwc_pkg::RAW_W'(cfg.span)) ? raw - rtwc_pkg::RAW_W'(cfg.span) : raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= accept && keep;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_acc_r <= s1_acc_nxt;
      s1_sy_r  <= in_data.symbol_number;
      s1_op_r  <= in_data.opcode;
    end
    if (s2_adv && s1_v_r) begin
      s2_lin_r <= fold[rtwc_pkg::LIN_W-1:0];
      s2_op_r  <= s1_op_r;
    end
  end

  assign push          = s2_v_r && !full;
  assign push_data.op  = s2_op_r;
  assign push_data.lin = s2_lin_r;

  `RTWC_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready, s1_v_r && s2_v_r && full)
  `RTWC_ASSERT_IMP(a_lin_in_span, clk, rst_n, push, s2_lin_r < cfg.span)

endmodule
`default_nettype wire

[rtl/core/rtwc_back.sv]
// Back part: tracks air time, classifies messages against the window,
// keeps counters and extremes and drives the result register. Depends on rtwc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rx_timing_window_checker_assert.svh"
module rtwc_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  rtwc_pkg::entry_t  pop_data,
  input  wire logic         empty,
  output logic              pop,
  input  rtwc_pkg::cfg_t    cfg,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rtwc_pkg::out_t    out_data
);

  localparam int DW = rtwc_pkg::DIST_W;

  logic [rtwc_pkg::LIN_W-1:0]  air_r;
  logic [COUNT_WIDTH-1:0]      on_r, early_r, late_r;
  logic [COUNT_WIDTH-1:0]      rep_on_r, rep_early_r, rep_late_r;
  logic signed [DW-1:0]        min_r, max_r;
  logic                        min_valid_r;
  logic                        out_valid_r;
  rtwc_pkg::out_t              out_r, out_nxt;

  logic                        is_tick, out_free;
  logic signed [DW-1:0]        d0, d, span_s, half, ws_ext, we_ext;
  logic                        late, early;
  logic [1:0]                  kind;

  assign is_tick  = (pop_data.op == rtwc_pkg::OP_TICK);
  assign out_free = !out_valid_r || out_ready;
  assign pop      = !empty && (is_tick || out_free);

  assign span_s = {1'b0, cfg.span};
  assign half   = {2'b00, cfg.span[rtwc_pkg::LIN_W-1:1]};
  assign ws_ext = {{(DW - rtwc_pkg::WIN_W){cfg.window_start[rtwc_pkg::WIN_W-1]}},
                   cfg.window_start};
  assign we_ext = {{(DW - rtwc_pkg::WIN_W){cfg.window_end[rtwc_pkg::WIN_W-1]}},
                   cfg.window_end};

  assign d0 = $signed({1'b0, air_r}) - $signed({1'b0, pop_data.lin});

  // wrap into [-span/2, span/2)
  always_comb begin
    if (d0 >= half) begin
      d = d0 - span_s;
    end else if (d0 < -half) begin
      d = d0 + span_s;
    end else begin
      d = d0;
    end
  end

  assign late  = d > we_ext;
  assign early = !late && (d < ws_ext);
  assign kind  = late ? rtwc_pkg::KIND_LATE : (early ? rtwc_pkg::KIND_EARLY
                                                     : rtwc_pkg::KIND_ON_TIME);

  always_comb begin
    out_nxt = '0;
    if (pop_data.op == rtwc_pkg::OP_MSG) begin
      out_nxt.kind     = kind;
      out_nxt.distance = d[rtwc_pkg::OUT_DIST_W-1:0];
    end else begin
      out_nxt.kind              = rtwc_pkg::KIND_REPORT;
      out_nxt.on_time_delta     = rtwc_pkg::DELTA_W'(on_r - rep_on_r);
      out_nxt.early_delta       = rtwc_pkg::DELTA_W'(early_r - rep_early_r);
      out_nxt.late_delta        = rtwc_pkg::DELTA_W'(late_r - rep_late_r);
      out_nxt.earliest_distance = min_valid_r ? min_r[rtwc_pkg::OUT_DIST_W-1:0] : '0;
      out_nxt.latest_distance   = max_r[rtwc_pkg::OUT_DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_r       <= '0;
      on_r        <= '0;
      early_r     <= '0;
      late_r      <= '0;
      rep_on_r    <= '0;
      rep_early_r <= '0;
      rep_late_r  <= '0;
      min_r       <= '0;
      min_valid_r <= 1'b0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && !is_tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        case (pop_data.op)
          rtwc_pkg::OP_TICK: begin
            air_r <= pop_data.lin;
          end
          rtwc_pkg::OP_MSG: begin
            if (!min_valid_r || d < min_r) begin
              min_r <= d;
            end
            min_valid_r <= 1'b1;
            if (d > max_r) begin
              max_r <= d;
            end
            if (late) begin
              late_r <= late_r + 1'b1;
            end else if (early) begin
              early_r <= early_r + 1'b1;
            end else begin
              on_r <= on_r + 1'b1;
            end
          end
          rtwc_pkg::OP_REPORT: begin
            rep_on_r    <= on_r;
            rep_early_r <= early_r;
            rep_late_r  <= late_r;
            min_valid_r <= 1'b0;
            min_r       <= '0;
            max_r       <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_tick) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RTWC_ASSERT_IMP(a_max_not_negative, clk, rst_n, 1'b1, !max_r[DW-1])
  `RTWC_ASSERT_IMP(a_min_below_max, clk, rst_n, min_valid_r, min_r <= max_r)
  `RTWC_ASSERT_NEXT(a_report_clears, clk, rst_n, pop && pop_data.op == rtwc_pkg::OP_REPORT,
                    !min_valid_r && max_r == '0 && out_valid_r)

endmodule
`default_nettype wire

[rtl/core/rx_timing_window_checker.sv]
// Receive timing window checker: one transaction per cycle sustained while out_ready stays high.
// A result leaves the output register after the two linearization stages,
// the queue and the classify step; ticks give none.
// Throughput is set by the classify step in the back part.
// Synchronous active-low reset clears configuration to defaults, air time,
// counters and extremes; the block accepts right after reset.
`timescale 1ns / 1ps
`default_nettype none
module rx_timing_window_checker #(
  parameter int COUNT_WIDTH = 32,
  parameter int FIFO_DEPTH  = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  rtwc_pkg::in_t                           in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rtwc_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [rtwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtwc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                            enable_r;
  logic [2:0]                      numerology_r;
  logic [3:0]                      sps_r;
  logic [rtwc_pkg::WIN_W-1:0]      wstart_r, wend_r;

  rtwc_pkg::cfg_t    cfg;
  rtwc_pkg::entry_t  push_data, pop_data;
  logic              push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      numerology_r <= 3'd1;
      sps_r        <= 4'd14;
      wstart_r     <= '0;
      wend_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtwc_pkg::REG_ENABLE:       enable_r     <= cfg_wdata[0];
        rtwc_pkg::REG_NUMEROLOGY:   numerology_r <= cfg_wdata[2:0];
        rtwc_pkg::REG_SYM_PER_SLOT: sps_r        <= cfg_wdata[3:0];
        rtwc_pkg::REG_WINDOW_START: wstart_r     <= cfg_wdata[rtwc_pkg::WIN_W-1:0];
        rtwc_pkg::REG_WINDOW_END:   wend_r       <= cfg_wdata[rtwc_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp numerology, treat anything but 12 as normal prefix
  assign cfg.enable       = enable_r;
  assign cfg.mu           = (numerology_r > rtwc_pkg::MU_MAX) ? rtwc_pkg::MU_MAX : numerology_r;
  assign cfg.ext_cp       = (sps_r == rtwc_pkg::SPS_EXT);
  assign cfg.span         = rtwc_pkg::span_symbols(cfg.mu, cfg.ext_cp);
  assign cfg.window_start = wstart_r;
  assign cfg.window_end   = wend_r;

  rtwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  rtwc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  rtwc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .empty     (empty),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
